// ===== rtl/core/esc_pkg.sv =====
package esc_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_TEMP    = 3'd0;
    localparam logic [2:0] REG_PRESS_A = 3'd1;
    localparam logic [2:0] REG_PRESS_B = 3'd2;
    localparam logic [2:0] REG_MIXED   = 3'd3;
    localparam logic [2:0] REG_HUM     = 3'd4;

    // depth of the queue between front and back
    localparam int QDepth = 2;
    localparam int QAw    = 1;

    // raw reading held in the queue
    typedef struct packed {
        logic [19:0] adc_t;
        logic [19:0] adc_p;
        logic [15:0] adc_h;
    } t_raw;

    // finished result
    typedef struct packed {
        logic        invalid;
        logic [16:0] hum;
        logic [31:0] press;
        logic [31:0] fine;
        logic [31:0] temp;
    } t_res;

    // sequencer states of the back part
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEMP,
        ST_MATH,
        ST_DIV,
        ST_POST,
        ST_DONE
    } t_state;

    // arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        asr = 32'($signed(x) >>> n);
    endfunction

    // 32-bit wrapping product
    function automatic logic [31:0] mul(input logic [31:0] x, input logic [31:0] y);
        mul = 32'(x * y);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

// ===== rtl/core/env_sensor_compensation_core.sv =====
// a request passes the front queue, then the sequencer's temperature, math,
// 32-step divide and post steps; the divide is skipped when the pressure divisor
// is zero; the sequencer takes a new request only when idle; the front
// queue holds two and one finished result waits in the output register
// reset: synchronous active low; calibration registers clear to zero,
// queue and sequencer empty
module env_sensor_compensation_core
    import esc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40]
    input  logic [55:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // temperature_centi [31:0], fine_temperature [63:32], pressure_pa [95:64],
    // humidity_q10 [112:96], pressure_invalid [113], zero [119:114]
    output logic [119:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    logic [47:0] r_cal_t, r_cal_m;
    logic [63:0] r_cal_pa, r_cal_pb;
    logic [39:0] r_cal_h;
    logic [2:0]  w_idx;
    t_raw        w_in, w_q;
    logic        w_qv, w_qr;
    t_res        w_res;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    // calibration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t  <= '0;
            r_cal_pa <= '0;
            r_cal_pb <= '0;
            r_cal_m  <= '0;
            r_cal_h  <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_TEMP:    r_cal_t  <= pwdata[47:0];
                REG_PRESS_A: r_cal_pa <= pwdata;
                REG_PRESS_B: r_cal_pb <= pwdata;
                REG_MIXED:   r_cal_m  <= pwdata[47:0];
                REG_HUM:     r_cal_h  <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_idx)
            REG_TEMP:    prdata = {16'd0, r_cal_t};
            REG_PRESS_A: prdata = r_cal_pa;
            REG_PRESS_B: prdata = r_cal_pb;
            REG_MIXED:   prdata = {16'd0, r_cal_m};
            REG_HUM:     prdata = {24'd0, r_cal_h};
            default:     prdata = '0;
        endcase
    end

    assign w_in.adc_t = s_axis_tdata[19:0];
    assign w_in.adc_p = s_axis_tdata[39:20];
    assign w_in.adc_h = s_axis_tdata[55:40];

    esc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_raw   (w_in),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_raw   (w_q)
    );

    esc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qv),
        .o_ready  (w_qr),
        .i_raw    (w_q),
        .i_cal_t  (r_cal_t),
        .i_cal_pa (r_cal_pa),
        .i_cal_pb (r_cal_pb),
        .i_cal_m  (r_cal_m),
        .i_cal_h  (r_cal_h),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.invalid, w_res.hum, w_res.press,
                           w_res.fine, w_res.temp};

    // humidity never exceeds its clamp
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_res.hum <= 17'd102400))
        else $error("humidity out of range");

    // invalid pressure reads as zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_res.invalid) |-> (w_res.press == '0))
        else $error("invalid pressure not zero");

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule

// ===== rtl/core/esc_front.sv =====
module esc_front
    import esc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_raw        i_raw,
    output logic        o_valid,
    input  logic        i_ready,
    output t_raw        o_raw
);
    // small fifo of accepted readings
    t_raw             r_mem [QDepth];
    logic [QAw-1:0]   r_wp, r_rp;
    logic [QAw:0]     r_cnt;
    logic             w_push, w_pop;

    assign o_ready = (r_cnt != (QAw+1)'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_raw   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // payload store
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_raw;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAw+1)'(w_push) - (QAw+1)'(w_pop);
        end
    end
endmodule

// ===== rtl/core/esc_div.sv =====
module esc_div
    import esc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quo
);
    // restoring divider, one quotient bit a cycle
    logic [31:0] r_rem, r_quo, r_den;
    logic [5:0]  r_cnt;
    logic [32:0] w_trial;
    logic [32:0] w_sub;

    assign w_trial = {r_rem, r_quo[31]};
    assign w_sub   = w_trial - {1'b0, r_den};
    assign o_busy  = (r_cnt != '0);
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (o_busy) begin
            if (!w_sub[32]) begin
                r_rem <= w_sub[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end
endmodule

// ===== rtl/core/esc_back.sv =====
module esc_back
    import esc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_raw         i_raw,
    input  logic [47:0]  i_cal_t,
    input  logic [63:0]  i_cal_pa,
    input  logic [63:0]  i_cal_pb,
    input  logic [47:0]  i_cal_m,
    input  logic [39:0]  i_cal_h,
    output logic         o_valid,
    input  logic         i_ready,
    output t_res         o_res
);
    // micro-step sequencer: one multiply per step into a register
    t_state      r_state, n_state;
    logic [4:0]  r_step;
    logic        r_ph;
    t_raw        r_raw;
    logic [31:0] r_v [14];
    logic [31:0] r_p;
    t_res        r_res;
    logic        r_ovalid;
    logic        r_inv;
    logic        r_div_start_q;
    logic        w_div_busy, w_div_start;
    logic [31:0] w_quo, w_num, w_den;
    logic [31:0] w_mx, w_my, r_prod;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] at, ap, ah;

    assign t1 = {16'd0, i_cal_t[15:0]};
    assign t2 = sx16(i_cal_t[31:16]);
    assign t3 = sx16(i_cal_t[47:32]);
    assign p1 = {16'd0, i_cal_pa[15:0]};
    assign p2 = sx16(i_cal_pa[31:16]);
    assign p3 = sx16(i_cal_pa[47:32]);
    assign p4 = sx16(i_cal_pa[63:48]);
    assign p5 = sx16(i_cal_pb[15:0]);
    assign p6 = sx16(i_cal_pb[31:16]);
    assign p7 = sx16(i_cal_pb[47:32]);
    assign p8 = sx16(i_cal_pb[63:48]);
    assign p9 = sx16(i_cal_m[15:0]);
    assign h1 = {24'd0, i_cal_m[23:16]};
    assign h2 = sx16(i_cal_m[39:24]);
    assign h3 = {24'd0, i_cal_m[47:40]};
    assign h4 = sx16(i_cal_h[15:0]);
    assign h5 = sx16(i_cal_h[31:16]);
    assign h6 = {{24{i_cal_h[39]}}, i_cal_h[39:32]};
    assign at = {12'd0, r_raw.adc_t};
    assign ap = {12'd0, r_raw.adc_p};
    assign ah = {16'd0, r_raw.adc_h};

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    // register map of temporaries:
    // 0 fine, 1 a, 2 d, 3 b, 4 tmp, 5 pa, 6 pd, 7 pb, 8 ha, 9 hb, 10 hd, 11 hx, 13 temp
    // shared multiplier operands per step
    always_comb begin
        w_mx = '0;
        w_my = '0;
        case (r_step)
            5'd0:  begin w_mx = (at >> 3) - (t1 << 1); w_my = t2; end
            5'd1:  begin w_mx = (at >> 4) - t1;        w_my = (at >> 4) - t1; end
            5'd2:  begin w_mx = asr(r_v[2], 12);       w_my = t3; end
            5'd3:  begin w_mx = r_v[0];                w_my = 32'd5; end
            // pressure
            5'd4:  begin w_mx = r_v[6];                w_my = r_v[6]; end
            5'd5:  begin w_mx = asr(r_v[4], 11);       w_my = p6; end
            5'd6:  begin w_mx = r_v[5];                w_my = p5; end
            5'd7:  begin w_mx = p3;                    w_my = asr(r_v[4], 13); end
            5'd8:  begin w_mx = p2;                    w_my = r_v[5]; end
            5'd9:  begin w_mx = 32'd32768 + r_v[1];    w_my = p1; end
            5'd10: begin w_mx = (32'd1048576 - ap) - asr(r_v[7], 12);
                         w_my = 32'd3125; end
            // humidity
            5'd11: begin w_mx = h5;                    w_my = r_v[8]; end
            5'd12: begin w_mx = r_v[8];                w_my = h6; end
            5'd13: begin w_mx = r_v[8];                w_my = h3; end
            5'd14: begin w_mx = asr(r_v[10], 10);      w_my = asr(r_v[11], 11) + 32'd32768; end
            5'd15: begin w_mx = asr(r_v[10], 10) + 32'd2097152; w_my = h2; end
            5'd16: begin w_mx = r_v[9];                w_my = r_v[10]; end
            5'd17: begin w_mx = asr(r_v[11], 15);      w_my = asr(r_v[11], 15); end
            5'd18: begin w_mx = asr(r_v[10], 7);       w_my = h1; end
            // pressure after division
            5'd19: begin w_mx = r_p >> 3;              w_my = r_p >> 3; end
            5'd20: begin w_mx = p9;                    w_my = r_v[2] >> 13; end
            5'd21: begin w_mx = r_p >> 2;              w_my = p8; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul(w_mx, w_my);
    end

    // divider operands, started once the scaled pressure is in r_p
    assign w_num = r_p[31] ? r_p : (r_p << 1);
    assign w_den = r_v[1];
    assign w_div_start = (r_state == ST_MATH) && (r_step == 5'd11) && !r_ph
                         && (r_v[1] != '0);

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_TEMP;
            ST_TEMP: if (r_step == 5'd3) n_state = ST_MATH;
            ST_MATH: if (r_step == 5'd18 && r_ph) n_state = ST_DIV;
            ST_DIV:  if (!w_div_busy && !r_div_start_q) n_state = ST_POST;
            ST_POST: if (r_step == 5'd22) n_state = ST_DONE;
            ST_DONE: if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_div_start_q <= 1'b0;
        else          r_div_start_q <= w_div_start;
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DONE && n_state == ST_IDLE) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // datapath: each step stores the registered product in its second phase (r_ph high)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ph     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && i_valid) begin
                r_raw  <= i_raw;
                r_step <= '0;
                r_ph   <= 1'b0;
            end else if (r_state == ST_DIV) begin
                r_step <= 5'd19;
                r_ph   <= 1'b0;
                if (!w_div_busy && !r_div_start_q && !r_inv) begin
                    r_p <= r_p[31] ? {w_quo[30:0], 1'b0} : w_quo;
                end
            end else if (r_state != ST_IDLE && r_state != ST_DONE) begin
                r_ph <= ~r_ph;
                if (r_ph) begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        5'd0: r_v[1] <= asr(r_prod, 11);
                        5'd1: r_v[2] <= r_prod;
                        5'd2: begin
                            r_v[0] <= r_v[1] + asr(r_prod, 14);
                            r_v[5] <= asr(r_v[1] + asr(r_prod, 14), 1) - 32'd64000;
                            r_v[6] <= asr(asr(r_v[1] + asr(r_prod, 14), 1) - 32'd64000, 2);
                            r_v[8] <= r_v[1] + asr(r_prod, 14) - 32'd76800;
                        end
                        5'd3: r_v[13] <= asr(r_prod + 32'd128, 8);
                        5'd4: r_v[4] <= r_prod;
                        5'd5: r_v[7] <= r_prod;
                        5'd6: r_v[7] <= asr(r_v[7] + (r_prod << 1), 2) + (p4 << 16);
                        5'd7: r_v[3] <= asr(r_prod, 3);
                        5'd8: r_v[1] <= asr(r_v[3] + asr(r_prod, 1), 18);
                        5'd9: r_v[1] <= asr(r_prod, 15);
                        5'd10: r_p <= r_prod;
                        5'd11: r_v[9] <= asr(((ah << 14) - (h4 << 20) - r_prod)
                                        + 32'd16384, 15);
                        5'd12: r_v[10] <= r_prod;
                        5'd13: r_v[11] <= r_prod;
                        5'd14: r_v[10] <= r_prod;
                        5'd15: r_v[10] <= asr(r_prod + 32'd8192, 14);
                        5'd16: r_v[11] <= r_prod;
                        5'd17: r_v[10] <= r_prod;
                        5'd18: r_v[11] <= r_v[11] - asr(r_prod, 4);
                        5'd19: r_v[2] <= r_prod;
                        5'd20: r_v[3] <= asr(r_prod, 12);
                        5'd21: r_v[12] <= r_prod;
                        default: ;
                    endcase
                end
            end
        end
    end

    // division guard flag
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MATH && r_step == 5'd10 && r_ph) begin
            r_inv <= (r_v[1] == '0);
        end
    end

    // final result assembly
    logic [31:0] w_hum_a, w_press;
    always_comb begin
        w_hum_a = r_v[11];
        if (w_hum_a[31]) w_hum_a = '0;
        if (w_hum_a > 32'd419430400) w_hum_a = 32'd419430400;
        w_press = r_inv ? '0
                : r_p + asr(r_v[3] + asr(r_v[12], 13) + p7, 4);
    end

    // output register, loaded only when the previous result has left
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && n_state == ST_IDLE) begin
            r_res.temp    <= r_v[13];
            r_res.fine    <= r_v[0];
            r_res.press   <= w_press;
            r_res.hum     <= w_hum_a[28:12];
            r_res.invalid <= r_inv;
        end
    end
endmodule

// ===== tb/tb_env_sensor_compensation_core.sv =====
`timescale 1ns / 100ps

module tb_env_sensor_compensation_core;
    import esc_pkg::*;

    typedef struct {
        logic [19:0] raw_t;
        logic [19:0] raw_p;
        logic [15:0] raw_h;
    } t_reading;

    typedef struct {
        logic [31:0] temp_centi;
        logic [31:0] fine_temp;
        logic [31:0] press_pa;
        logic [16:0] hum_q10;
        logic        press_bad;
    } t_comp;

    localparam int WatchLimit = 20000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    // calibration copy
    logic [47:0] cal_t;
    logic [63:0] cal_pa;
    logic [63:0] cal_pb;
    logic [47:0] cal_m;
    logic [39:0] cal_h;

    t_reading reading_q[$];
    t_comp    comp_q[$];
    int       mismatches;
    int       idle_pct_s;
    int       idle_pct_m;
    int       hold_off;
    int       watch_cnt;

    env_sensor_compensation_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] s16(input logic [63:0] w, input int pos);
        logic [15:0] v;
        v = w[pos +: 16];
        return {{16{v[15]}}, v};
    endfunction

    // compensation of one reading with the current calibration
    function automatic t_comp compensate(input t_reading r);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, d, fine, p, rt, rp, rh;
        t_comp c;
        rt = {12'd0, r.raw_t};
        rp = {12'd0, r.raw_p};
        rh = {16'd0, r.raw_h};
        t1 = {16'd0, cal_t[15:0]};
        t2 = s16(64'(cal_t), 16);
        t3 = s16(64'(cal_t), 32);
        p1 = {16'd0, cal_pa[15:0]};
        p2 = s16(cal_pa, 16);
        p3 = s16(cal_pa, 32);
        p4 = s16(cal_pa, 48);
        p5 = s16(cal_pb, 0);
        p6 = s16(cal_pb, 16);
        p7 = s16(cal_pb, 32);
        p8 = s16(cal_pb, 48);
        p9 = s16(64'(cal_m), 0);
        h1 = {24'd0, cal_m[23:16]};
        h2 = s16(64'(cal_m), 24);
        h3 = {24'd0, cal_m[47:40]};
        h4 = s16(64'(cal_h), 0);
        h5 = s16(64'(cal_h), 16);
        h6 = {{24{cal_h[39]}}, cal_h[39:32]};
        c.press_bad = 1'b0;
        // temperature
        a = sra(((rt >> 3) - (t1 << 1)) * t2, 11);
        d = (rt >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        fine = a + b;
        c.fine_temp = fine;
        c.temp_centi = sra(fine * 32'd5 + 32'd128, 8);
        // pressure
        a = sra(fine, 1) - 32'd64000;
        d = sra(a, 2);
        b = sra(d * d, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(p3 * sra(d * d, 13), 3) + sra(p2 * a, 1), 18);
        a = sra((32'd32768 + a) * p1, 15);
        if (a == '0) begin
            p = '0;
            c.press_bad = 1'b1;
        end else begin
            p = ((32'd1048576 - rp) - sra(b, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / a;
            else p = (p / a) * 32'd2;
            d = p >> 3;
            a = sra(p9 * ((d * d) >> 13), 12);
            b = sra((p >> 2) * p8, 13);
            p = p + sra(a + b + p7, 4);
        end
        c.press_pa = p;
        // humidity
        a = fine - 32'd76800;
        b = sra(((rh << 14) - (h4 << 20) - (h5 * a)) + 32'd16384, 15);
        d = sra(a * h6, 10) * (sra(a * h3, 11) + 32'd32768);
        d = sra((sra(d, 10) + 32'd2097152) * h2 + 32'd8192, 14);
        a = b * d;
        d = sra(a, 15);
        a = a - sra(sra(d * d, 7) * h1, 4);
        if (a[31]) a = '0;
        if (a > 32'd419430400) a = 32'd419430400;
        c.hum_q10 = 17'(a >> 12);
        return c;
    endfunction

    // driver: offers pending readings, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                comp_q.push_back(compensate(reading_q.pop_front()));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (reading_q.size() > 0 && $urandom_range(99) >= idle_pct_s) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {reading_q[0].raw_h, reading_q[0].raw_p,
                                     reading_q[0].raw_t};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks results against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (comp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end else begin
                    t_comp e;
                    e = comp_q.pop_front();
                    if (m_axis_tdata[31:0] !== e.temp_centi ||
                            m_axis_tdata[63:32] !== e.fine_temp ||
                            m_axis_tdata[95:64] !== e.press_pa ||
                            m_axis_tdata[112:96] !== e.hum_q10 ||
                            m_axis_tdata[113] !== e.press_bad ||
                            m_axis_tdata[119:114] !== 6'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: exp t=%h f=%h p=%h h=%h i=%b got %h",
                                e.temp_centi, e.fine_temp, e.press_pa, e.hum_q10,
                                e.press_bad, m_axis_tdata);
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct_m);
            end
        end
    end

    // watchdog on cycles without any handshake or register access while work is pending
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                psel) begin
            watch_cnt <= 0;
        end else if (reading_q.size() > 0 || comp_q.size() > 0) begin
            watch_cnt <= watch_cnt + 1;
            if (watch_cnt >= WatchLimit) begin
                $display("env_sensor_compensation_core: mismatch");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TEMP:    cal_t = val[47:0];
            REG_PRESS_A: cal_pa = val;
            REG_PRESS_B: cal_pb = val;
            REG_MIXED:   cal_m = val[47:0];
            REG_HUM:     cal_h = val[39:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (reading_q.size() > 0 || comp_q.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic add_reading(input logic [19:0] t, input logic [19:0] p,
            input logic [15:0] h);
        t_reading r;
        r.raw_t = t;
        r.raw_p = p;
        r.raw_h = h;
        reading_q.push_back(r);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // typical factory coefficient set
    task automatic load_typical();
        write_reg(REG_TEMP, 64'({16'd50, 16'd26435, 16'd27504}));
        write_reg(REG_PRESS_A, {16'd2855, 16'd3024, 16'hD6D0, 16'd36477});
        write_reg(REG_PRESS_B, {16'd15500, 16'hC1F0, 16'hFFF9, 16'd140});
        write_reg(REG_MIXED, 64'({8'd0, 16'd362, 8'd75, 16'd6000}));
        write_reg(REG_HUM, 64'({8'd30, 16'd50, 16'd300}));
    endtask

    initial begin
        int k;
        int ph;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        idle_pct_s = 32;
        idle_pct_m = 32;
        hold_off = 0;
        cal_t = '0;
        cal_pa = '0;
        cal_pb = '0;
        cal_m = '0;
        cal_h = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero coefficients after reset: zero divisor case
        add_reading(20'd0, 20'd0, 16'd0);
        add_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        wait_drained();

        // directed readings with typical coefficients
        load_typical();
        add_reading(20'd519888, 20'd415148, 16'd27000);
        add_reading(20'd0, 20'd0, 16'd0);
        add_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        add_reading(20'hFFFFF, 20'd0, 16'd0);
        add_reading(20'd0, 20'hFFFFF, 16'hFFFF);
        add_reading(20'h80000, 20'h80000, 16'h8000);
        add_reading(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
        add_reading(20'd400000, 20'd300000, 16'd60000);
        wait_drained();

        // extreme coefficient words
        write_reg(REG_TEMP, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_PRESS_A, '1);
        write_reg(REG_PRESS_B, '1);
        write_reg(REG_MIXED, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_HUM, 64'hFF_FFFF_FFFF);
        add_reading(20'd0, 20'd0, 16'd0);
        add_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        add_reading(20'd519888, 20'd415148, 16'd27000);
        wait_drained();
        write_reg(REG_TEMP, 64'h8000_8000_8000);
        write_reg(REG_PRESS_A, 64'h8000_8000_8000_8000);
        write_reg(REG_PRESS_B, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_MIXED, 64'h80_8000_80_8000);
        write_reg(REG_HUM, 64'h80_8000_8000);
        add_reading(20'd0, 20'd0, 16'd0);
        add_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        add_reading(20'h55555, 20'hAAAAA, 16'h5555);
        wait_drained();

        // random phases: typical, partly bounded random or fully random coefficients
        for (ph = 0; ph < 12; ph++) begin
            if (ph % 3 == 0) begin
                load_typical();
            end else if (ph % 3 == 1) begin
                write_reg(REG_TEMP, 64'({16'($urandom_range(100)),
                    16'($urandom_range(30000)), 16'($urandom_range(20000, 40000))}));
                write_reg(REG_PRESS_A, {rand64()} & 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(REG_PRESS_B, rand64());
                write_reg(REG_MIXED, rand64());
                write_reg(REG_HUM, rand64());
            end else begin
                write_reg(REG_TEMP, rand64());
                write_reg(REG_PRESS_A, rand64());
                write_reg(REG_PRESS_B, rand64());
                write_reg(REG_MIXED, rand64());
                write_reg(REG_HUM, rand64());
            end
            idle_pct_s = (ph == 4) ? 0 : 32;
            idle_pct_m = (ph == 4) ? 0 : 32;
            if (ph == 6) hold_off = 3000;
            for (k = 0; k < 100; k++) begin
                if ($urandom_range(3) == 0)
                    add_reading(20'($urandom), 20'($urandom), 16'($urandom));
                else
                    add_reading(20'($urandom_range(300000, 700000)),
                        20'($urandom_range(200000, 500000)), 16'($urandom_range(20000, 50000)));
            end
            wait_drained();
        end

        if (mismatches == 0 && comp_q.size() == 0) begin
            $display("env_sensor_compensation_core: match");
        end else begin
            $display("env_sensor_compensation_core: mismatch");
        end
        $finish;
    end

endmodule
